// ===== rtl/rrsv_pkg.sv =====
// Package for the rounded rectangle strip vertex generator.
// Shared types, register indexes, corner codes and series constants.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package rrsv_pkg;

    // Arc point count: default and largest supported value
    localparam int ARC_POINTS_DEF = 80;
    localparam int ARC_POINTS_MAX = 120;
    localparam int ARC_IDX_W      = $clog2(ARC_POINTS_MAX);

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RECT_WIDTH    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RECT_HEIGHT   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CORNER_RADIUS = 3'd4;

    // Corner codes
    localparam logic [1:0] CORNER_TL = 2'd0;
    localparam logic [1:0] CORNER_TR = 2'd1;
    localparam logic [1:0] CORNER_BR = 2'd2;
    localparam logic [1:0] CORNER_BL = 2'd3;

    // Series constants, Q30 angles
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [63:0] ONE_Q30     = 64'd1073741824;

    // Factor pairs that divide successive Taylor terms
    localparam logic [63:0] TAYLOR_DIV_COS [1:11] =
        '{64'd2, 64'd12, 64'd30, 64'd56, 64'd90, 64'd132,
          64'd182, 64'd240, 64'd306, 64'd380, 64'd462};
    localparam logic [63:0] TAYLOR_DIV_SIN [1:11] =
        '{64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156,
          64'd210, 64'd272, 64'd342, 64'd420, 64'd506};

    // Configuration register file contents
    typedef struct packed {
        logic signed [15:0] origin_x;
        logic signed [15:0] origin_y;
        logic        [14:0] rect_width;
        logic        [14:0] rect_height;
        logic        [14:0] corner_radius;
    } t_cfg;

    // Per-vertex control from the sequencer to the datapath
    typedef struct packed {
        logic [ARC_IDX_W-1:0] k;
        logic [1:0]           corner;
        logic                 last;
        logic [14:0]          radius;
    } t_vtx_ctrl;

endpackage

`default_nettype wire

// ===== rtl/rrsv_in_if.sv =====
// Input channel of the vertex generator: one beat per vertex request.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface rrsv_in_if;
    logic valid;
    logic ready;
    logic restart;

    modport source (output valid, output restart, input ready);
    modport sink   (input valid, input restart, output ready);
endinterface

`default_nettype wire

// ===== rtl/rrsv_out_if.sv =====
// Output channel of the vertex generator: one beat per strip vertex.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface rrsv_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] vertex_x;
    logic signed [15:0] vertex_y;
    logic               last_vertex;

    modport source (output valid, output vertex_x, output vertex_y, output last_vertex,
                    input ready);
    modport sink   (input valid, input vertex_x, input vertex_y, input last_vertex,
                    output ready);
endinterface

`default_nettype wire

// ===== rtl/rounded_rect_strip_vertex_gen_unit.sv =====
// Top level of the rounded rectangle strip vertex generator.
// Depends on rrsv_pkg, rrsv_in_if, rrsv_out_if, rrsv_seq and rrsv_datapath.
//
//   channel  dir  beat                                 handshake
//   i_in     in   restart                              valid/ready
//   o_out    out  vertex_x, vertex_y, last_vertex      valid/ready
//   cfg      in   i_cfg_idx, i_cfg_wdata               i_cfg_we, no wait
//
// Three register stages (sequencer, arc scaling, output): a request beat is
// registered in the sequencer, then in the arc scaling stage, then on o_out.
// One beat is accepted every cycle unless the output stalls; the arc table
// read and the two 15x15 radius multiplies in the middle stage set the cycle time.
// Reset clears the strip position, the latched radius, all stage valids
// and the configuration registers.
// A stalled output holds every stage; bubbles between stages are filled.
`timescale 1ns / 1ps
`default_nettype none

module rounded_rect_strip_vertex_gen_unit #(
    parameter int ARC_POINTS = rrsv_pkg::ARC_POINTS_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [rrsv_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [rrsv_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    rrsv_in_if.sink                             i_in,
    rrsv_out_if.source                          o_out
);

    rrsv_pkg::t_cfg      r_cfg;
    rrsv_pkg::t_vtx_ctrl w_ctrl;
    logic                w_s1_valid;
    logic                w_ds_ready;

    // Configuration register file
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                rrsv_pkg::REG_ORIGIN_X:      r_cfg.origin_x      <= signed'(i_cfg_wdata);
                rrsv_pkg::REG_ORIGIN_Y:      r_cfg.origin_y      <= signed'(i_cfg_wdata);
                rrsv_pkg::REG_RECT_WIDTH:    r_cfg.rect_width    <= i_cfg_wdata[14:0];
                rrsv_pkg::REG_RECT_HEIGHT:   r_cfg.rect_height   <= i_cfg_wdata[14:0];
                rrsv_pkg::REG_CORNER_RADIUS: r_cfg.corner_radius <= i_cfg_wdata[14:0];
                default: ;
            endcase
        end
    end

    rrsv_seq #(
        .ARC_POINTS (ARC_POINTS)
    ) u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_in       (i_in),
        .i_ds_ready (w_ds_ready),
        .o_valid    (w_s1_valid),
        .o_ctrl     (w_ctrl)
    );

    rrsv_datapath #(
        .ARC_POINTS (ARC_POINTS)
    ) u_datapath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (w_s1_valid),
        .i_ctrl  (w_ctrl),
        .o_ready (w_ds_ready),
        .o_out   (o_out)
    );

endmodule

`default_nettype wire

// ===== rtl/rrsv_arc_rom.sv =====
// Quarter-circle cosine/sine table in Q14, built at elaboration.
// Depends on rrsv_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rrsv_arc_rom #(
    parameter int ARC_POINTS = rrsv_pkg::ARC_POINTS_DEF
) (
    input  wire logic [rrsv_pkg::ARC_IDX_W-1:0] i_k,
    output logic      [14:0]                    o_cos,
    output logic      [14:0]                    o_sin
);

    localparam int IDX_W = $clog2(ARC_POINTS);

    // Taylor series in Q30, clamped to [0,1], rounded to Q14
    function automatic logic [14:0] arc_q14(input int unsigned k_idx, input logic want_sin);
        logic [63:0] a;
        logic [63:0] x2;
        logic [63:0] t;
        logic [63:0] v;
        longint      sum;
        a  = (64'(k_idx) * rrsv_pkg::HALF_PI_Q30) / ARC_POINTS;
        x2 = (a * a) >> 30;
        t  = want_sin ? a : rrsv_pkg::ONE_Q30;
        sum = longint'(t);
        for (int term = 1; term < 12; term++) begin
            if (want_sin) begin
                t = ((t * x2) >> 30) / rrsv_pkg::TAYLOR_DIV_SIN[term];
            end else begin
                t = ((t * x2) >> 30) / rrsv_pkg::TAYLOR_DIV_COS[term];
            end
            if (term % 2 == 1) begin
                sum = sum - longint'(t);
            end else begin
                sum = sum + longint'(t);
            end
        end
        if (sum < 0) begin
            sum = 0;
        end
        if (sum > longint'(rrsv_pkg::ONE_Q30)) begin
            sum = longint'(rrsv_pkg::ONE_Q30);
        end
        v = (64'(sum) + 64'd32768) >> 16;
        return v[14:0];
    endfunction

    logic [14:0] w_cos_tbl [ARC_POINTS];
    logic [14:0] w_sin_tbl [ARC_POINTS];

    for (genvar g = 0; g < ARC_POINTS; g++) begin : g_tbl
        localparam logic [14:0] CosVal = arc_q14(g, 1'b0);
        localparam logic [14:0] SinVal = arc_q14(g, 1'b1);
        assign w_cos_tbl[g] = CosVal;
        assign w_sin_tbl[g] = SinVal;
    end

    // Table read; indexes past the arc read as zero
    always_comb begin
        if (i_k < rrsv_pkg::ARC_IDX_W'(ARC_POINTS)) begin
            o_cos = w_cos_tbl[i_k[IDX_W-1:0]];
            o_sin = w_sin_tbl[i_k[IDX_W-1:0]];
        end else begin
            o_cos = '0;
            o_sin = '0;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/rrsv_seq.sv =====
// Strip sequencer: vertex position, radius latch, corner and arc index.
// Depends on rrsv_pkg and rrsv_in_if.
`timescale 1ns / 1ps
`default_nettype none

module rrsv_seq #(
    parameter int ARC_POINTS = rrsv_pkg::ARC_POINTS_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire rrsv_pkg::t_cfg       i_cfg,
    rrsv_in_if.sink                   i_in,
    input  wire logic                 i_ds_ready,
    output logic                      o_valid,
    output rrsv_pkg::t_vtx_ctrl       o_ctrl
);

    localparam int STRIP_LEN = 4 * ARC_POINTS + 6;
    localparam int POS_W     = $clog2(STRIP_LEN);

    logic [POS_W-1:0]    r_pos;
    logic [POS_W-1:0]    n_pos;
    logic [14:0]         r_radius;
    logic [14:0]         n_radius;
    logic                r_valid;
    rrsv_pkg::t_vtx_ctrl r_ctrl;
    rrsv_pkg::t_vtx_ctrl n_ctrl;

    logic             w_s1_ready;
    logic             w_acc;
    logic [POS_W-1:0] w_p;
    logic [POS_W-1:0] w_q;
    logic [POS_W-1:0] w_k_top;
    logic [14:0]      w_min_side;
    logic [16:0]      w_auto_num;
    logic [31:0]      w_auto_prod;
    logic [14:0]      w_auto_rad;

    assign w_s1_ready = !r_valid || i_ds_ready;
    assign i_in.ready = w_s1_ready;
    assign w_acc      = i_in.valid && w_s1_ready;

    // Position of this beat, restart forces the first vertex
    assign w_p   = i_in.restart ? '0 : r_pos;
    assign n_pos = (w_p == POS_W'(STRIP_LEN - 1)) ? '0 : w_p + 1'b1;

    // Ten percent of the smaller side, rounded: floor((2m+10)/20) = floor(((2m+10)>>2)/5)
    assign w_min_side  = (i_cfg.rect_width < i_cfg.rect_height) ?
                         i_cfg.rect_width : i_cfg.rect_height;
    assign w_auto_num  = {1'b0, w_min_side, 1'b0} + 17'd10;
    assign w_auto_prod = 32'(w_auto_num[16:2]) * 32'd52429;
    assign w_auto_rad  = 15'(w_auto_prod >> 18);

    // Radius latched at strip start
    always_comb begin
        n_radius = r_radius;
        if (w_p == '0) begin
            n_radius = (i_cfg.corner_radius != '0) ? i_cfg.corner_radius : w_auto_rad;
        end
    end

    // Corner and arc index for this position
    assign w_k_top = POS_W'(ARC_POINTS - 1) - (w_p >> 1);
    assign w_q     = w_p - POS_W'(2 * ARC_POINTS + 6);

    always_comb begin
        n_ctrl.radius = n_radius;
        n_ctrl.last   = (w_p == POS_W'(STRIP_LEN - 1));
        if (w_p < POS_W'(2 * ARC_POINTS)) begin
            n_ctrl.k      = rrsv_pkg::ARC_IDX_W'(w_k_top);
            n_ctrl.corner = w_p[0] ? rrsv_pkg::CORNER_TR : rrsv_pkg::CORNER_TL;
        end else if (w_p < POS_W'(2 * ARC_POINTS + 3)) begin
            n_ctrl.k      = '0;
            n_ctrl.corner = rrsv_pkg::CORNER_TR;
        end else if (w_p == POS_W'(2 * ARC_POINTS + 3)) begin
            n_ctrl.k      = '0;
            n_ctrl.corner = rrsv_pkg::CORNER_TL;
        end else if (w_p == POS_W'(2 * ARC_POINTS + 4)) begin
            n_ctrl.k      = '0;
            n_ctrl.corner = rrsv_pkg::CORNER_BR;
        end else if (w_p == POS_W'(2 * ARC_POINTS + 5)) begin
            n_ctrl.k      = '0;
            n_ctrl.corner = rrsv_pkg::CORNER_BL;
        end else begin
            n_ctrl.k      = rrsv_pkg::ARC_IDX_W'(w_q >> 1);
            n_ctrl.corner = w_q[0] ? rrsv_pkg::CORNER_BL : rrsv_pkg::CORNER_BR;
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos    <= '0;
            r_radius <= '0;
            r_valid  <= 1'b0;
        end else begin
            if (w_s1_ready) begin
                r_valid <= i_in.valid;
            end
            if (w_acc) begin
                r_pos    <= n_pos;
                r_radius <= n_radius;
            end
        end
    end

    // Input stage payload
    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_ctrl <= n_ctrl;
        end
    end

    assign o_valid = r_valid;
    assign o_ctrl  = r_ctrl;

`ifndef SYNTHESIS
    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos < POS_W'(STRIP_LEN))
        else $error("strip position out of range");

    a_restart_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && i_in.restart) |=> (r_valid && r_ctrl.corner == rrsv_pkg::CORNER_TL
            && r_ctrl.k == rrsv_pkg::ARC_IDX_W'(ARC_POINTS - 1)))
        else $error("restart did not start at the first top-left vertex");

    a_last_bl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_ctrl.last) |-> (r_ctrl.corner == rrsv_pkg::CORNER_BL
            && r_ctrl.k == rrsv_pkg::ARC_IDX_W'(ARC_POINTS - 1)))
        else $error("last vertex is not the final bottom-left point");
`endif

endmodule

`default_nettype wire

// ===== rtl/rrsv_datapath.sv =====
// Vertex datapath: arc scaling by the radius, edge sums, saturation, output register.
// Depends on rrsv_pkg, rrsv_arc_rom and rrsv_out_if.
`timescale 1ns / 1ps
`default_nettype none

module rrsv_datapath #(
    parameter int ARC_POINTS = rrsv_pkg::ARC_POINTS_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire rrsv_pkg::t_cfg       i_cfg,
    input  wire logic                 i_valid,
    input  wire rrsv_pkg::t_vtx_ctrl  i_ctrl,
    output logic                      o_ready,
    rrsv_out_if.source                o_out
);

    // Clamp an 18-bit sum to the signed 16-bit range
    function automatic logic signed [15:0] sat16(input logic signed [17:0] v);
        if (v > 18'sd32767) begin
            return 16'sh7fff;
        end else if (v < -18'sd32768) begin
            return 16'sh8000;
        end else begin
            return v[15:0];
        end
    endfunction

    logic [14:0] w_cos;
    logic [14:0] w_sin;
    logic [29:0] w_cprod;
    logic [29:0] w_sprod;
    logic [30:0] w_cround;
    logic [30:0] w_sround;

    logic        r2_valid;
    logic [15:0] r2_cr;
    logic [15:0] r2_sr;
    logic [1:0]  r2_corner;
    logic        r2_last;
    logic [14:0] r2_radius;

    logic               r_out_valid;
    logic signed [15:0] r_out_x;
    logic signed [15:0] r_out_y;
    logic               r_out_last;
    logic signed [15:0] n_out_x;
    logic signed [15:0] n_out_y;

    logic               w_out_free;
    logic               w_s2_ready;
    logic signed [17:0] w_ox;
    logic signed [17:0] w_oy;
    logic signed [17:0] w_r;
    logic signed [17:0] w_cr;
    logic signed [17:0] w_sr;
    logic signed [17:0] w_xl;
    logic signed [17:0] w_xr;
    logic signed [17:0] w_yt;
    logic signed [17:0] w_yb;

    assign w_out_free = !r_out_valid || o_out.ready;
    assign w_s2_ready = !r2_valid || w_out_free;
    assign o_ready    = w_s2_ready;

    rrsv_arc_rom #(
        .ARC_POINTS (ARC_POINTS)
    ) u_rom (
        .i_k   (i_ctrl.k),
        .o_cos (w_cos),
        .o_sin (w_sin)
    );

    // Scaled arc offsets, rounded half up from Q14
    assign w_cprod  = 30'(w_cos) * 30'(i_ctrl.radius);
    assign w_sprod  = 30'(w_sin) * 30'(i_ctrl.radius);
    assign w_cround = 31'(w_cprod) + 31'd8192;
    assign w_sround = 31'(w_sprod) + 31'd8192;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else if (w_s2_ready) begin
            r2_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s2_ready && i_valid) begin
            r2_cr     <= 16'(w_cround >> 14);
            r2_sr     <= 16'(w_sround >> 14);
            r2_corner <= i_ctrl.corner;
            r2_last   <= i_ctrl.last;
            r2_radius <= i_ctrl.radius;
        end
    end

    // Edge coordinates, exact in 18 bits
    assign w_ox = 18'(i_cfg.origin_x);
    assign w_oy = 18'(i_cfg.origin_y);
    assign w_r  = signed'({3'b000, r2_radius});
    assign w_cr = signed'({2'b00, r2_cr});
    assign w_sr = signed'({2'b00, r2_sr});
    assign w_xl = w_ox + w_r - w_cr;
    assign w_xr = w_ox + signed'({3'b000, i_cfg.rect_width}) - w_r + w_cr;
    assign w_yt = w_oy - w_r + w_sr;
    assign w_yb = w_oy - signed'({3'b000, i_cfg.rect_height}) + w_r - w_sr;

    // Corner selection
    always_comb begin
        case (r2_corner)
            rrsv_pkg::CORNER_TL: begin
                n_out_x = sat16(w_xl);
                n_out_y = sat16(w_yt);
            end
            rrsv_pkg::CORNER_TR: begin
                n_out_x = sat16(w_xr);
                n_out_y = sat16(w_yt);
            end
            rrsv_pkg::CORNER_BR: begin
                n_out_x = sat16(w_xr);
                n_out_y = sat16(w_yb);
            end
            default: begin
                n_out_x = sat16(w_xl);
                n_out_y = sat16(w_yb);
            end
        endcase
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_free) begin
            r_out_valid <= r2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_free && r2_valid) begin
            r_out_x    <= n_out_x;
            r_out_y    <= n_out_y;
            r_out_last <= r2_last;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.vertex_x    = r_out_x;
    assign o_out.vertex_y    = r_out_y;
    assign o_out.last_vertex = r_out_last;

`ifndef SYNTHESIS
    a_mid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r2_valid && !w_out_free) |=> (r2_valid && $stable(r2_cr) && $stable(r2_sr)))
        else $error("middle stage lost or changed a stalled vertex");
`endif

endmodule

`default_nettype wire
